// ----- hdl/tree_lca_by_parent_climb_macros.svh -----
// Assertion shorthands for the LCA block; clock i_clk, reset i_rst_n (active low).
`ifndef TREE_LCA_BY_PARENT_CLIMB_MACROS_SVH
`define TREE_LCA_BY_PARENT_CLIMB_MACROS_SVH

// Same-cycle implication.
`define TLCA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TLCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tlca_pkg.sv -----
package tlca_pkg;

    localparam int NODE_W    = 10;
    localparam int MAX_NODES = 1 << NODE_W;
    localparam int CNT_W     = 11;
    localparam int GUARD_W   = $clog2(2 * MAX_NODES + 1);

    localparam logic [GUARD_W-1:0] LVL_LIMIT  = GUARD_W'(2 * MAX_NODES);
    localparam logic [GUARD_W-1:0] MEET_LIMIT = GUARD_W'(MAX_NODES);
    localparam logic [CNT_W-1:0]   CNT_RESET  = CNT_W'(MAX_NODES);

    // op codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // node count in use: zero acts as one, anything past the table as the full table
    function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] nc);
        logic [CNT_W-1:0] res;
        if (nc == '0) begin
            res = CNT_W'(1);
        end else if (nc > CNT_W'(MAX_NODES)) begin
            res = CNT_W'(MAX_NODES);
        end else begin
            res = nc;
        end
        return res;
    endfunction

endpackage

// ----- hdl/tlca_ram.sv -----
// Simple dual-port RAM, one write and one registered read per cycle.
module tlca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tree_lca_by_parent_climb.sv -----
// Channel   | Signals                                   | Dir | Word
// ----------+-------------------------------------------+-----+-----------------------------
// input     | i_in_valid, o_in_stall, i_op, i_node_a/b  | in  | op, two node indexes
// output    | o_out_valid, i_out_stall, o_ancestor      | out | common ancestor (queries only)
// config    | i_cfg_valid, o_cfg_ready, i_cfg_data      | in  | node_count
//
// Build climbs the parent chain of each of the n nodes in use; a rooted node
// climbs its depth, an unrooted one n steps.
// Query reads both depths, then takes at most 2*1024 levelling steps and 1024
// meeting steps; a levelling step reads a parent then its depth, a meeting
// step reads the parents of both nodes in turn.
// Reset (synchronous, active low) sets control and node_count (full table) only; no RAM sweep.
// o_in_stall is high while any item is in work; a finished query waits for the
// output register, which holds its word through i_out_stall.
`include "tree_lca_by_parent_climb_macros.svh"

module tree_lca_by_parent_climb import tlca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input word
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_op,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    // result word
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [NODE_W-1:0] o_ancestor,
    // config word
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_BCHK  = 12'b0000_0000_0010,  // start climb for node r_v
        S_BSTEP = 12'b0000_0000_0100,  // parent word arrives, climb on
        S_QDA   = 12'b0000_0000_1000,  // depth of a arrives
        S_QDB   = 12'b0000_0001_0000,  // depth of b arrives
        S_LVL   = 12'b0000_0010_0000,  // levelling decision
        S_QUP   = 12'b0000_0100_0000,  // parent of the deeper node arrives
        S_QDEP  = 12'b0000_1000_0000,  // its depth arrives
        S_MEET  = 12'b0001_0000_0000,  // meeting decision
        S_MA    = 12'b0010_0000_0000,  // parent of p arrives
        S_MB    = 12'b0100_0000_0000,  // parent of q arrives
        S_DONE  = 12'b1000_0000_0000   // hand result to output register
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_node_count, n_node_count;
    logic [CNT_W-1:0]  r_v, n_v;
    logic [NODE_W-1:0] r_cur, n_cur;
    logic [CNT_W-1:0]  r_steps, n_steps;
    logic [NODE_W-1:0] r_p, n_p;
    logic [NODE_W-1:0] r_q, n_q;
    logic [NODE_W-1:0] r_dp, n_dp;
    logic [NODE_W-1:0] r_dq, n_dq;
    logic [GUARD_W-1:0] r_guard, n_guard;
    logic              r_out_valid, n_out_valid;
    logic [NODE_W-1:0] r_ancestor, n_ancestor;

    logic              w_in_acc, w_cfg_acc, w_finish, w_up_p, w_keep;
    logic [CNT_W-1:0]  w_active, w_steps, w_v1;
    logic [NODE_W-1:0] w_climb, w_result;

    // parent RAM ports
    logic              w_p_we;
    logic [NODE_W-1:0] w_p_waddr, w_p_wdata, w_p_raddr, w_p_rdata;
    // depth RAM ports
    logic              w_d_we;
    logic [NODE_W-1:0] w_d_waddr, w_d_wdata, w_d_raddr, w_d_rdata;

    tlca_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_p_waddr),
        .i_wdata (w_p_wdata),
        .i_raddr (w_p_raddr),
        .o_rdata (w_p_rdata)
    );

    tlca_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (w_d_waddr),
        .i_wdata (w_d_wdata),
        .i_raddr (w_d_raddr),
        .o_rdata (w_d_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_ancestor  = r_ancestor;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_cfg_acc = i_cfg_valid && o_cfg_ready;
    assign w_active  = active_count(r_node_count);

    // build climb: in BCHK the walk starts at r_cur with no steps taken,
    // in BSTEP the RAM word is the next node up
    assign w_climb = (r_state == S_BSTEP) ? w_p_rdata : r_cur;
    assign w_steps = (r_state == S_BSTEP) ? r_steps + CNT_W'(1) : r_steps;
    assign w_keep  = (w_climb != '0) && (w_steps < w_active);
    assign w_v1    = r_v + CNT_W'(1);

    // deeper node moves during levelling (ties never reach QUP)
    assign w_up_p   = (r_dp > r_dq);
    assign w_result = (r_p == r_q) ? r_p : '0;
    assign w_finish = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state      = r_state;
        n_node_count = r_node_count;
        n_v          = r_v;
        n_cur        = r_cur;
        n_steps      = r_steps;
        n_p          = r_p;
        n_q          = r_q;
        n_dp         = r_dp;
        n_dq         = r_dq;
        n_guard      = r_guard;
        n_out_valid  = r_out_valid;
        n_ancestor   = r_ancestor;

        w_p_we    = 1'b0;
        w_p_waddr = i_node_a;
        w_p_wdata = i_node_b;
        w_p_raddr = r_p;
        w_d_we    = 1'b0;
        w_d_waddr = r_v[NODE_W-1:0];
        w_d_wdata = '0;
        w_d_raddr = r_q;

        if (w_cfg_acc) begin
            n_node_count = i_cfg_data;
        end

        if (o_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    priority case (i_op)
                        OP_LOAD: begin
                            w_p_we = 1'b1;
                        end
                        OP_BUILD: begin
                            n_v     = '0;
                            n_cur   = '0;
                            n_steps = '0;
                            n_state = S_BCHK;
                        end
                        OP_QUERY: begin
                            n_p       = i_node_a;
                            n_q       = i_node_b;
                            w_d_raddr = i_node_a;
                            n_state   = S_QDA;
                        end
                        default: ;  // unused code, dropped
                    endcase
                end
            end
            S_BCHK, S_BSTEP: begin
                if (w_keep) begin
                    w_p_raddr = w_climb;
                    n_cur     = w_climb;
                    n_steps   = w_steps;
                    n_state   = S_BSTEP;
                end else begin
                    // unrooted walk stores zero
                    w_d_we    = 1'b1;
                    w_d_wdata = (w_climb == '0) ? w_steps[NODE_W-1:0] : '0;
                    if (w_v1 == w_active) begin
                        n_state = S_IDLE;
                    end else begin
                        n_v     = w_v1;
                        n_cur   = w_v1[NODE_W-1:0];
                        n_steps = '0;
                        n_state = S_BCHK;
                    end
                end
            end
            S_QDA: begin
                n_dp      = w_d_rdata;
                w_d_raddr = r_q;
                n_state   = S_QDB;
            end
            S_QDB: begin
                n_dq    = w_d_rdata;
                n_guard = '0;
                n_state = S_LVL;
            end
            S_LVL: begin
                if ((r_dp != r_dq) && (r_guard < LVL_LIMIT)) begin
                    w_p_raddr = w_up_p ? r_p : r_q;
                    n_state   = S_QUP;
                end else begin
                    n_guard = '0;
                    n_state = S_MEET;
                end
            end
            S_QUP: begin
                if (w_up_p) begin
                    n_p = w_p_rdata;
                end else begin
                    n_q = w_p_rdata;
                end
                w_d_raddr = w_p_rdata;
                n_guard   = r_guard + GUARD_W'(1);
                n_state   = S_QDEP;
            end
            S_QDEP: begin
                if (w_up_p) begin
                    n_dp = w_d_rdata;
                end else begin
                    n_dq = w_d_rdata;
                end
                n_state = S_LVL;
            end
            S_MEET: begin
                if ((r_p != r_q) && (r_guard < MEET_LIMIT)) begin
                    w_p_raddr = r_p;
                    n_state   = S_MA;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MA: begin
                n_p       = w_p_rdata;
                w_p_raddr = r_q;
                n_state   = S_MB;
            end
            S_MB: begin
                n_q     = w_p_rdata;
                n_guard = r_guard + GUARD_W'(1);
                n_state = S_MEET;
            end
            S_DONE: begin
                if (w_finish) begin
                    n_out_valid = 1'b1;
                    n_ancestor  = w_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= CNT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node_count <= n_node_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_cur      <= n_cur;
        r_steps    <= n_steps;
        r_p        <= n_p;
        r_q        <= n_q;
        r_dp       <= n_dp;
        r_dq       <= n_dq;
        r_guard    <= n_guard;
        r_ancestor <= n_ancestor;
    end

    `TLCA_ASSERT_NOW(a_depth_wr_in_range, w_d_we, r_v < w_active, "depth write past node count")
    `TLCA_ASSERT_NOW(a_level_exit, (r_state == S_LVL) && (n_state == S_MEET), (r_dp == r_dq) || (r_guard == LVL_LIMIT), "meet phase entered with unequal depths")
    `TLCA_ASSERT_NOW(a_meet_bound, r_state == S_MEET, r_guard <= MEET_LIMIT, "meet guard overrun")
    `TLCA_ASSERT_NEXT(a_result_loaded, w_finish, o_out_valid && (o_ancestor == $past(w_result)), "result word not loaded")

endmodule
